/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define DRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define DRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/drf_pkg.sv */
// shared types and constants of the dhcp reply filter
`default_nettype none

package drf_pkg;

  localparam int HEADER_BYTES_DEF    = 42;
  localparam int MAX_FRAME_BYTES_DEF = 2048;

  localparam int POS_W       = 12;
  localparam int FIXED_BYTES = 240;

  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  typedef enum logic [1:0] {
    REG_XID      = 2'd0,
    REG_MAC      = 2'd1,
    REG_OP       = 2'd2,
    REG_MSG_TYPE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    VERD_OK        = 3'd0,
    VERD_XID_BAD   = 3'd1,
    VERD_MAC_BAD   = 3'd2,
    VERD_TYPE_BAD  = 3'd3,
    VERD_TOO_SHORT = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [31:0] expected_xid;
    logic [47:0] client_mac;
    logic [7:0]  expected_op;
    logic [7:0]  expected_msg_type;
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    verdict_t   verdict;
    logic       type_found;
    logic [7:0] type_value;
  } result_t;

endpackage

`default_nettype wire

/* hdl/dhcp_reply_filter.sv */
// top level: stream input register, byte parser, verdict output register
// path: a last byte passes the input register, then the output register, before its verdict shows on out_*
// throughput: one frame byte per cycle, limited only by the output register when
//   a finished verdict is not taken (only last bytes wait for it)
// reset: synchronous active-low rst_n clears frame state, pipeline valids and
//   loads register reset values (xid 0, mac 0, op 2, message type 2)
`default_nettype none

module dhcp_reply_filter #(
  parameter int HEADER_BYTES    = drf_pkg::HEADER_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = drf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input stream
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] packet_byte
  input  wire logic                       in_tlast,   // last_byte
  // result stream
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [15:0]                out_tdata,  // [0] accepted, [3:1] verdict,
                                                      // [4] type_found, [12:5] type_value
  // configuration port
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [drf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [drf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [drf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  drf_pkg::cfg_t    cfg;
  drf_pkg::result_t res;

  // input register stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // output register stage
  logic             out_valid_r;
  drf_pkg::result_t out_res_r;

  logic out_free;
  logic fire;

  assign cfg_pready = 1'b1;

  drf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // a middle byte always moves on; a last byte needs room in the output register
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  drf_parser #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (fire),
    .packet_byte (in_byte_r),
    .last_byte   (in_last_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r.type_value, out_res_r.type_found,
                       out_res_r.verdict, out_res_r.accepted};

endmodule

`default_nettype wire

/* hdl/drf_cfg_regs.sv */
// apb register file holding the expected reply fields
`default_nettype none

module drf_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [drf_pkg::CFG_AW-1:0] paddr,
  input  wire logic [drf_pkg::CFG_DW-1:0] pwdata,
  output logic      [drf_pkg::CFG_DW-1:0] prdata,
  output drf_pkg::cfg_t                   cfg
);

  drf_pkg::cfg_t     cfg_r;
  drf_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = drf_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_xid      <= '0;
      cfg_r.client_mac        <= '0;
      cfg_r.expected_op       <= 8'd2;
      cfg_r.expected_msg_type <= 8'd2;
    end else if (wr_en) begin
      case (idx)
        drf_pkg::REG_XID:      cfg_r.expected_xid      <= pwdata[31:0];
        drf_pkg::REG_MAC:      cfg_r.client_mac        <= pwdata[47:0];
        drf_pkg::REG_OP:       cfg_r.expected_op       <= pwdata[7:0];
        drf_pkg::REG_MSG_TYPE: cfg_r.expected_msg_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      drf_pkg::REG_XID:      prdata = {32'd0, cfg_r.expected_xid};
      drf_pkg::REG_MAC:      prdata = {16'd0, cfg_r.client_mac};
      drf_pkg::REG_OP:       prdata = {56'd0, cfg_r.expected_op};
      drf_pkg::REG_MSG_TYPE: prdata = {56'd0, cfg_r.expected_msg_type};
      default:               prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hdl/drf_parser.sv */
// per-frame byte parser: header checks, option walk and verdict
`default_nettype none

module drf_parser #(
  parameter int HEADER_BYTES    = drf_pkg::HEADER_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = drf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_en,
  input  wire logic [7:0]    packet_byte,
  input  wire logic          last_byte,
  input  drf_pkg::cfg_t      cfg,
  output drf_pkg::result_t   res
);

  localparam int PW        = drf_pkg::POS_W;
  localparam int SHORT_LIM = HEADER_BYTES + drf_pkg::FIXED_BYTES - 1;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  logic [PW-1:0] pos_r, pos_nxt;
  logic          xid_bad_r, xid_bad_nxt;
  logic          mac_bad_r, mac_bad_nxt;
  logic          op_bad_r, op_bad_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    skip_r, skip_nxt;
  logic          target_r, target_nxt;
  logic          done_r, done_nxt;
  logic          seen_r, seen_nxt;
  logic [7:0]    value_r, value_nxt;

  logic [PW-1:0] rel;
  logic          in_window;
  logic          short_frame;
  logic [7:0]    xid_want;
  logic [7:0]    mac_want;

  assign in_window   = (pos_r < PW'(MAX_FRAME_BYTES)) && (pos_r >= PW'(HEADER_BYTES));
  assign rel         = pos_r - PW'(HEADER_BYTES);
  assign short_frame = pos_r < PW'(SHORT_LIM);

  // xid bytes arrive most significant first
  always_comb begin
    case (rel[1:0])
      2'd0:    xid_want = cfg.expected_xid[31:24];
      2'd1:    xid_want = cfg.expected_xid[23:16];
      2'd2:    xid_want = cfg.expected_xid[15:8];
      default: xid_want = cfg.expected_xid[7:0];
    endcase
  end

  always_comb begin
    case (rel[5:0])
      6'd28:   mac_want = cfg.client_mac[47:40];
      6'd29:   mac_want = cfg.client_mac[39:32];
      6'd30:   mac_want = cfg.client_mac[31:24];
      6'd31:   mac_want = cfg.client_mac[23:16];
      6'd32:   mac_want = cfg.client_mac[15:8];
      default: mac_want = cfg.client_mac[7:0];
    endcase
  end

  always_comb begin
    pos_nxt     = (pos_r < PW'(MAX_FRAME_BYTES)) ? pos_r + PW'(1) : pos_r;
    xid_bad_nxt = xid_bad_r;
    mac_bad_nxt = mac_bad_r;
    op_bad_nxt  = op_bad_r;
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    target_nxt  = target_r;
    done_nxt    = done_r;
    seen_nxt    = seen_r;
    value_nxt   = value_r;

    if (in_window) begin
      if (rel == PW'(0)) begin
        op_bad_nxt = packet_byte != cfg.expected_op;
      end else if (rel >= PW'(4) && rel <= PW'(7)) begin
        if (packet_byte != xid_want) xid_bad_nxt = 1'b1;
      end else if (rel >= PW'(28) && rel <= PW'(33)) begin
        if (packet_byte != mac_want) mac_bad_nxt = 1'b1;
      end else if (rel >= PW'(drf_pkg::FIXED_BYTES) && !done_r) begin
        // every option but the end marker, pad included, is type, length, data
        case (phase_r)
          PH_TYPE: begin
            if (packet_byte == drf_pkg::OPT_END) begin
              done_nxt = 1'b1;
            end else begin
              target_nxt = packet_byte == drf_pkg::OPT_MSG_TYPE;
              phase_nxt  = PH_LEN;
            end
          end
          PH_LEN: begin
            if (target_r) begin
              if (packet_byte == 8'd0) done_nxt = 1'b1;
              else phase_nxt = PH_DATA;
            end else begin
              skip_nxt  = packet_byte;
              phase_nxt = (packet_byte == 8'd0) ? PH_TYPE : PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_nxt = skip_r - 8'd1;
            if (skip_r == 8'd1) phase_nxt = PH_TYPE;
          end
          default: begin
            seen_nxt  = 1'b1;
            value_nxt = packet_byte;
            done_nxt  = 1'b1;
          end
        endcase
      end
    end
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    if (short_frame)
      res.verdict = drf_pkg::VERD_TOO_SHORT;
    else if (xid_bad_nxt)
      res.verdict = drf_pkg::VERD_XID_BAD;
    else if (mac_bad_nxt)
      res.verdict = drf_pkg::VERD_MAC_BAD;
    else if (op_bad_nxt || !seen_nxt || value_nxt != cfg.expected_msg_type)
      res.verdict = drf_pkg::VERD_TYPE_BAD;
    else
      res.verdict = drf_pkg::VERD_OK;
    res.accepted   = res.verdict == drf_pkg::VERD_OK;
    res.type_found = seen_nxt;
    res.type_value = seen_nxt ? value_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      pos_r     <= '0;
      xid_bad_r <= 1'b0;
      mac_bad_r <= 1'b0;
      op_bad_r  <= 1'b0;
      phase_r   <= PH_TYPE;
      skip_r    <= '0;
      target_r  <= 1'b0;
      done_r    <= 1'b0;
      seen_r    <= 1'b0;
      value_r   <= '0;
    end else if (byte_en) begin
      pos_r     <= pos_nxt;
      xid_bad_r <= xid_bad_nxt;
      mac_bad_r <= mac_bad_nxt;
      op_bad_r  <= op_bad_nxt;
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      target_r  <= target_nxt;
      done_r    <= done_nxt;
      seen_r    <= seen_nxt;
      value_r   <= value_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/drf_checker.sv */
// port-level checker for the dhcp reply filter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module drf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic verd_ok;
  logic verd_range;
  logic type_clear;

  assign verd_ok    = out_tdata[3:1] == drf_pkg::VERD_OK;
  assign verd_range = out_tdata[3:1] <= drf_pkg::VERD_TOO_SHORT;
  assign type_clear = out_tdata[4] || (out_tdata[12:5] == 8'd0);

  `DRF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result lost while stalled")
  `DRF_ASSERT(a_accept_match, out_tvalid |-> out_tdata[0] == verd_ok, "accept flag mismatch")
  `DRF_ASSERT(a_verdict_range, out_tvalid |-> verd_range, "verdict code out of range")
  `DRF_ASSERT(a_type_zero, out_tvalid |-> type_clear, "type value without type option")
  `DRF_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> !out_tvalid, "valid right after reset")

endmodule

bind dhcp_reply_filter drf_checker u_drf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* bench/reply_check_pkg.sv */
`timescale 1ns / 100ps
// scoreboard class: byte-level verdict prediction and result checking for the reply filter
package reply_check_pkg;
  import drf_pkg::*;

  typedef enum logic [1:0] {
    WALK_TYPE,
    WALK_LEN,
    WALK_SKIP,
    WALK_DATA
  } walk_phase_t;

  class reply_scoreboard;
    int unsigned hdr_bytes;
    int unsigned max_bytes;

    logic [31:0] xid_reg;
    logic [47:0] mac_reg;
    logic [7:0]  op_reg;
    logic [7:0]  type_reg;

    int unsigned pos;
    logic        xid_miss;
    logic        mac_miss;
    logic        op_miss;
    walk_phase_t phase;
    logic [7:0]  skip_cnt;
    logic        on_type_opt;
    logic        walk_done;
    logic        type_seen;
    logic [7:0]  type_byte;

    result_t     verdict_q[$];
    int unsigned errors;
    int unsigned checked;

    function new(int unsigned hdr, int unsigned maxb);
      hdr_bytes = hdr;
      max_bytes = maxb;
      xid_reg   = '0;
      mac_reg   = '0;
      op_reg    = 8'd2;
      type_reg  = 8'd2;
      errors    = 0;
      checked   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos         = 0;
      xid_miss    = 1'b0;
      mac_miss    = 1'b0;
      op_miss     = 1'b0;
      phase       = WALK_TYPE;
      skip_cnt    = '0;
      on_type_opt = 1'b0;
      walk_done   = 1'b0;
      type_seen   = 1'b0;
      type_byte   = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_XID:      xid_reg  = value[31:0];
        REG_MAC:      mac_reg  = value[47:0];
        REG_OP:       op_reg   = value[7:0];
        REG_MSG_TYPE: type_reg = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // one accepted input byte; queues a verdict on the last byte of a frame
    function void note_byte(logic [7:0] b, logic last);
      int unsigned rel;
      logic        too_short;
      result_t     r;
      if (pos >= hdr_bytes && pos < max_bytes) begin
        rel = pos - hdr_bytes;
        if (rel == 0) begin
          op_miss = (b != op_reg);
        end else if (rel >= 4 && rel <= 7) begin
          if (b != xid_reg[8*(7-rel) +: 8]) xid_miss = 1'b1;
        end else if (rel >= 28 && rel <= 33) begin
          if (b != mac_reg[8*(33-rel) +: 8]) mac_miss = 1'b1;
        end else if (rel >= FIXED_BYTES && !walk_done) begin
          // option walk, option 0 counts as a full tlv
          case (phase)
            WALK_TYPE: begin
              if (b == OPT_END) begin
                walk_done = 1'b1;
              end else begin
                on_type_opt = (b == OPT_MSG_TYPE);
                phase       = WALK_LEN;
              end
            end
            WALK_LEN: begin
              if (on_type_opt) begin
                if (b == 8'd0) walk_done = 1'b1;
                else phase = WALK_DATA;
              end else begin
                skip_cnt = b;
                phase    = (b == 8'd0) ? WALK_TYPE : WALK_SKIP;
              end
            end
            WALK_SKIP: begin
              skip_cnt = skip_cnt - 8'd1;
              if (skip_cnt == 8'd0) phase = WALK_TYPE;
            end
            default: begin
              type_seen = 1'b1;
              type_byte = b;
              walk_done = 1'b1;
            end
          endcase
        end
      end
      too_short = (pos < hdr_bytes + FIXED_BYTES - 1);
      if (pos < max_bytes) pos++;
      if (!last) return;

      if (too_short) r.verdict = VERD_TOO_SHORT;
      else if (xid_miss) r.verdict = VERD_XID_BAD;
      else if (mac_miss) r.verdict = VERD_MAC_BAD;
      else if (op_miss || !type_seen || type_byte != type_reg) r.verdict = VERD_TYPE_BAD;
      else r.verdict = VERD_OK;
      r.accepted   = (r.verdict == VERD_OK);
      r.type_found = type_seen;
      r.type_value = type_seen ? type_byte : 8'd0;
      verdict_q.push_back(r);
      clear_frame();
    endfunction

    function void check_verdict(logic [15:0] d);
      result_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $error("verdict transaction with none expected: tdata %h", d);
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (d[0] !== want.accepted) begin
        errors++;
        $error("accepted: expected %0d, got %0d", want.accepted, d[0]);
      end
      if (d[3:1] !== want.verdict) begin
        errors++;
        $error("verdict: expected %0d, got %0d", want.verdict, d[3:1]);
      end
      if (d[4] !== want.type_found) begin
        errors++;
        $error("type_found: expected %0d, got %0d", want.type_found, d[4]);
      end
      if (d[12:5] !== want.type_value) begin
        errors++;
        $error("type_value: expected %0d, got %0d", want.type_value, d[12:5]);
      end
      if (d[15:13] !== 3'b000) begin
        errors++;
        $error("pad: expected 0, got %0d", d[15:13]);
      end
    endfunction
  endclass

endpackage

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench top: drives frames and register writes into the reply filter and checks verdicts
module tb;
  import drf_pkg::*;
  import reply_check_pkg::*;

  localparam int HDR         = HEADER_BYTES_DEF;
  localparam int MAXB        = MAX_FRAME_BYTES_DEF;
  localparam int OP_AT       = HDR;
  localparam int XID_AT      = HDR + 4;
  localparam int MAC_AT      = HDR + 28;
  localparam int FIXED_END   = HDR + FIXED_BYTES;
  localparam int QUIET_LIMIT = 4000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;   // [7:0] packet_byte
  logic              in_tlast    = 1'b0; // last_byte
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [15:0]       out_tdata;          // [0] accepted, [3:1] verdict, [4] type_found,
                                         // [12:5] type_value
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  reply_scoreboard sb;
  logic [7:0]      frame_q[$];     // frame under construction, first byte in front
  int              send_idle  = 0; // percent of cycles the sender holds back
  int              recv_stall = 0; // percent of cycles the receiver stalls
  int              quiet      = 0;
  int              frames_sent = 0;
  int              bytes_sent  = 0;
  int              cfg_writes  = 0;

  always #4 clk = ~clk;

  dhcp_reply_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // monitor: both channels sampled at the edge, values seen are the pre-edge ones;
  // the watchdog counts cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("** dhcp_reply_filter: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // fixed part of a reply that matches the current registers; header bytes are random
  function automatic void start_reply();
    int         rel;
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < FIXED_END; i++) begin
      b   = 8'($urandom);
      rel = i - HDR;
      if (rel == 0) b = sb.op_reg;
      else if (rel >= 4 && rel <= 7) b = sb.xid_reg[8*(7-rel) +: 8];
      else if (rel >= 28 && rel <= 33) b = sb.mac_reg[8*(33-rel) +: 8];
      frame_q.push_back(b);
    end
  endfunction

  // one tlv option, first data byte given, the rest random
  function automatic void add_opt(logic [7:0] code, int len, logic [7:0] first);
    frame_q.push_back(code);
    frame_q.push_back(8'(len));
    for (int i = 0; i < len; i++) frame_q.push_back((i == 0) ? first : 8'($urandom));
  endfunction

  // some option other than the message type or the end marker, mostly short
  function automatic void add_filler();
    logic [7:0] code;
    int         len;
    code = 8'($urandom_range(0, 254));
    if (code == OPT_MSG_TYPE) code = code + 8'd1;
    len = ($urandom_range(19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    add_opt(code, len, 8'($urandom));
  endfunction

  // hand the whole frame to the block, tlast on its final byte
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= frame_q[i];
      in_tlast  <= (i == frame_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    frames_sent++;
  endtask

  // stop sending and wait for every outstanding verdict plus the pipeline depth
  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb setup then access; psel stays up so writes can run back to back
  task automatic cfg_write(reg_idx_t idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_writes++;
  endtask

  task automatic program_regs(logic [31:0] xid, logic [47:0] mac, logic [7:0] op,
                              logic [7:0] mtype);
    cfg_write(REG_XID, 64'(xid));
    cfg_write(REG_MAC, 64'(mac));
    cfg_write(REG_OP, 64'(op));
    cfg_write(REG_MSG_TYPE, 64'(mtype));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int fault;
    int mode;
    sb = new(HDR, MAXB);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean reply under reset register values, message type as the only option
    start_reply();
    add_opt(OPT_MSG_TYPE, 1, sb.type_reg);
    frame_q.push_back(OPT_END);
    send_frame();

    // short frames in four flow-control mixes, registers changed between them
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) drain_verdicts();
      case (ph)
        1: begin
          program_regs('1, '1, 8'hff, 8'hff);
          send_idle = 88;
          recv_stall <= 0;
        end
        2: begin
          program_regs('0, '0, 8'h00, 8'h00);
          send_idle = 0;
          recv_stall <= 88;
        end
        3: begin
          program_regs($urandom, 48'({$urandom, $urandom}), 8'($urandom), 8'($urandom));
          send_idle = 35;
          recv_stall <= 35;
        end
        default: ;
      endcase
      for (int n = 0; n < 12; n++) begin
        frame_q.delete();
        repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
        send_frame();
      end
    end

    // one well-formed reply against the random registers, sometimes spoiled
    start_reply();
    fault = $urandom_range(99);
    if (fault < 8) frame_q[OP_AT] ^= 8'($urandom_range(1, 255));
    else if (fault < 16) frame_q[XID_AT + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
    else if (fault < 24) frame_q[MAC_AT + $urandom_range(5)] ^= 8'($urandom_range(1, 255));
    repeat ($urandom_range(0, 2)) add_filler();
    mode = $urandom_range(99);
    if (mode < 80) begin
      add_opt(OPT_MSG_TYPE, $urandom_range(1, 4),
              ($urandom_range(9) < 8) ? sb.type_reg : 8'($urandom));
    end else begin
      add_opt(OPT_MSG_TYPE, 0, 8'd0);
    end
    frame_q.push_back(OPT_END);
    send_frame();

    drain_verdicts();
    repeat (4) @(posedge clk);
    $display("sent %0d frames (%0d bytes), checked %0d verdicts, %0d register writes",
             frames_sent, bytes_sent, sb.checked, cfg_writes);
    $display("covered full replies and short frames under four stall mixes and four register sets");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** dhcp_reply_filter: PASSED **");
    end else begin
      $display("** dhcp_reply_filter: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/drf_pkg.sv
hdl/drf_cfg_regs.sv
hdl/drf_parser.sv
hdl/dhcp_reply_filter.sv
hdl/drf_checker.sv
bench/reply_check_pkg.sv
bench/tb.sv
